### design/gb3_pkg.sv
// ----------------------------------------------------------------------------
// gb3_pkg: shared types and constants for the 3x3 RGB Gaussian blur
// Payload structs of the pixel channels, configuration register indexes
// and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package gb3_pkg;

  // Default line store depth (largest supported row length)
  localparam int MAX_WIDTH = 2048;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  // Register field widths and reset values
  localparam int IMG_WIDTH_W  = 12;
  localparam int IMG_HEIGHT_W = 15;
  localparam int IMG_WIDTH_RST  = 640;
  localparam int IMG_HEIGHT_RST = 480;

  // Output row counter width (covers every height the register can hold)
  localparam int ROW_W = IMG_HEIGHT_W;

  typedef struct packed {
    logic       is_flush;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;
  } pix_out_t;

endpackage

`default_nettype wire

### design/gb3_ram.sv
// ----------------------------------------------------------------------------
// gb3_ram: simple dual-port RAM
// One write port and one read port; read data registered on read enable,
// read-first when both ports hit the same address.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/gaussian_blur_3x3_rgb.sv
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_rgb: streaming 3x3 Gaussian blur of 24-bit RGB pixels
// Kernel 1 2 1 / 2 4 2 / 1 2 1 per channel, zero outside the image, sum / 16.
// ----------------------------------------------------------------------------
// Usage:
//   in channel   (in_valid_i / in_ready_o / in_pix_i): pixels in raster order.
//     After the last pixel of a frame send width+1 flush transactions.
//   out channel  (out_valid_o / out_ready_i / out_pix_o): blurred pixels;
//     frame_last marks the final pixel of the frame.
//   cfg channel  (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
//     index 0 image_width, index 1 image_height. Always ready. A write starts
//     a new frame; write only while no transaction is in flight.
//   Throughput: one transaction per clock unless stalled. Each item does one read
//     and one write of the combined line store, which has one port of each kind.
//   Pipeline: an accepted item passes the work stage, whose result is held in
//     the output register; the blurred pixel of a centre leaves width+1 items
//     after that centre arrived.
//   Stall: with out_ready_i low, one item more is held in the work stage, then
//     in_ready_o drops until the output register drains.
//   Reset: counters and window cleared, 640 x 480; line store contents are
//     undefined and never reach a result unmasked.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_3x3_rgb #(
  parameter int MaxWidth = gb3_pkg::MAX_WIDTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire gb3_pkg::pix_in_t                 in_pix_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output gb3_pkg::pix_out_t                     out_pix_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [gb3_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [gb3_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import gb3_pkg::*;

  localparam int ColW     = $clog2(MaxWidth);
  localparam int WW       = $clog2(MaxWidth + 1);
  localparam int WidthRst = (IMG_WIDTH_RST > MaxWidth) ? MaxWidth : IMG_WIDTH_RST;

  // Input row progress, saturating
  localparam logic [1:0] ROW_FIRST  = 2'd0;
  localparam logic [1:0] ROW_SECOND = 2'd1;
  localparam logic [1:0] ROW_LATER  = 2'd2;

  // Kernel weights as shift amounts
  localparam logic [1:0] KERN_SHIFT [3][3] = '{'{2'd0, 2'd1, 2'd0},
                                              '{2'd1, 2'd2, 2'd1},
                                              '{2'd0, 2'd1, 2'd0}};

  // Configuration (effective values stored)
  logic [WW-1:0]           weff_q, weff_d;
  logic [IMG_HEIGHT_W-1:0] heff_q, heff_d;

  // Position counters
  logic [ColW-1:0]  icol_q;
  logic [1:0]       irow_q;
  logic [ColW-1:0]  oc_q;
  logic [ROW_W-1:0] orow_q;

  // Window columns 0 and 1, rows top to bottom
  logic [23:0] win_q [3][2];

  // Work stage
  logic            s1_valid_q;
  logic            s1_prod_q;
  logic [ColW-1:0] s1_col_q;
  logic [23:0]     s1_pix_q;
  logic            s1_fwd_q;
  logic [23:0]     s1_fup_q;
  logic [23:0]     s1_fmid_q;

  // Output register
  logic     out_valid_q;
  pix_out_t out_q, out_d;

  logic            cfg_acc, in_acc, s1_fire, s1_last, restart;
  logic [ColW-1:0] s0_col;
  logic [1:0]      s0_row;
  logic            s0_prod, s0_col_last, s0_fwd;
  logic [23:0]     s0_pix;
  logic [47:0]     ram_rdata;
  logic [23:0]     up_px, mid_px;
  logic [23:0]     newcol [3];
  logic [23:0]     nb_px [3][3];
  logic [11:0]     acc [3];
  logic            oc_last, orow_last;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;
  assign s1_fire     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_fire;
  assign in_acc      = in_valid_i && in_ready_o;

  // Effective register values
  always_comb begin
    weff_d = weff_q;
    heff_d = heff_q;
    case (cfg_index_i)
      CFG_IMAGE_WIDTH: begin
        if (cfg_data_i[IMG_WIDTH_W-1:0] == '0) begin
          weff_d = WW'(1);
        end else if (int'(cfg_data_i[IMG_WIDTH_W-1:0]) > MaxWidth) begin
          weff_d = WW'(MaxWidth);
        end else begin
          weff_d = WW'(cfg_data_i[IMG_WIDTH_W-1:0]);
        end
      end
      CFG_IMAGE_HEIGHT: begin
        heff_d = (cfg_data_i[IMG_HEIGHT_W-1:0] == '0) ? IMG_HEIGHT_W'(1)
                                                      : cfg_data_i[IMG_HEIGHT_W-1:0];
      end
      default: ;
    endcase
  end

  // Output position flags of the item in the work stage
  assign oc_last   = ((WW+1)'(oc_q) + (WW+1)'(1)) >= (WW+1)'(weff_q);
  assign orow_last = ((IMG_HEIGHT_W+1)'(orow_q) + (IMG_HEIGHT_W+1)'(1))
                     >= (IMG_HEIGHT_W+1)'(heff_q);
  assign s1_last   = oc_last && orow_last;
  assign restart   = s1_fire && s1_prod_q && s1_last;

  // Intake: the item taken with the frame's last result starts a new frame
  assign s0_col      = restart ? '0 : icol_q;
  assign s0_row      = restart ? ROW_FIRST : irow_q;
  assign s0_prod     = (s0_row == ROW_LATER) || (s0_row == ROW_SECOND && s0_col != '0);
  assign s0_col_last = ((WW+1)'(s0_col) + (WW+1)'(1)) >= (WW+1)'(weff_q);
  assign s0_pix      = in_pix_i.is_flush ? 24'd0
                       : {in_pix_i.in_red, in_pix_i.in_green, in_pix_i.in_blue};
  // Bypass the line store when the retiring item writes the column just read
  assign s0_fwd      = s1_fire && (s0_col == s1_col_q);

  // Line data for the work stage
  assign up_px  = s1_fwd_q ? s1_fup_q  : ram_rdata[47:24];
  assign mid_px = s1_fwd_q ? s1_fmid_q : ram_rdata[23:0];

  assign newcol[0] = up_px;
  assign newcol[1] = mid_px;
  assign newcol[2] = s1_pix_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nb_px[r][0] = win_q[r][0];
      nb_px[r][1] = win_q[r][1];
      // At column zero the centre is the last pixel of the previous row
      nb_px[r][2] = (s1_col_q == '0) ? 24'd0 : newcol[r];
    end
    // Mask neighbours outside the image
    for (int r = 0; r < 3; r++) begin
      if (oc_q == '0) nb_px[r][0] = 24'd0;
      if (oc_last)    nb_px[r][2] = 24'd0;
    end
    for (int c = 0; c < 3; c++) begin
      if (orow_q == '0) nb_px[0][c] = 24'd0;
      if (orow_last)    nb_px[2][c] = 24'd0;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          acc[ch] = acc[ch] + (12'(nb_px[r][c][(16 - 8*ch) +: 8]) << KERN_SHIFT[r][c]);
        end
      end
    end
    out_d.out_red    = acc[0][11:4];
    out_d.out_green  = acc[1][11:4];
    out_d.out_blue   = acc[2][11:4];
    out_d.frame_last = s1_last;
  end

  gb3_ram #(
    .Width (48),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i ({mid_px, s1_pix_q}),
    .re_i    (in_acc),
    .raddr_i (s0_col),
    .rdata_o (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weff_q      <= WW'(WidthRst);
      heff_q      <= IMG_HEIGHT_W'(IMG_HEIGHT_RST);
      icol_q      <= '0;
      irow_q      <= ROW_FIRST;
      oc_q        <= '0;
      orow_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= '0;
        win_q[r][1] <= '0;
      end
    end else if (cfg_acc) begin
      weff_q <= weff_d;
      heff_q <= heff_d;
      icol_q <= '0;
      irow_q <= ROW_FIRST;
      oc_q   <= '0;
      orow_q <= '0;
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= '0;
        win_q[r][1] <= '0;
      end
    end else begin
      if (in_acc) begin
        if (s0_col_last) begin
          icol_q <= '0;
          irow_q <= (s0_row == ROW_FIRST) ? ROW_SECOND : ROW_LATER;
        end else begin
          icol_q <= s0_col + ColW'(1);
          irow_q <= s0_row;
        end
      end else if (restart) begin
        icol_q <= '0;
        irow_q <= ROW_FIRST;
      end

      if (s1_fire && s1_prod_q) begin
        if (s1_last) begin
          oc_q   <= '0;
          orow_q <= '0;
        end else if (oc_last) begin
          oc_q   <= '0;
          orow_q <= orow_q + ROW_W'(1);
        end else begin
          oc_q <= oc_q + ColW'(1);
        end
      end

      // Shift the window one column
      if (s1_fire) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= newcol[r];
        end
      end

      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_fire && s1_prod_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_prod_q <= s0_prod;
      s1_col_q  <= s0_col;
      s1_pix_q  <= s0_pix;
      s1_fwd_q  <= s0_fwd;
      s1_fup_q  <= mid_px;
      s1_fmid_q <= s1_pix_q;
    end
    if (s1_fire && s1_prod_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_q;

  // The frame's last result leaves the output counters at the frame origin
  a_restart_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (restart && !cfg_acc) |=> (oc_q == '0 && orow_q == '0))
    else $error("output position not cleared after frame end");

  // Intake only stalls behind a full work stage and a blocked output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("intake stalled without back pressure");

  // A retiring item with no replacement empties the work stage
  a_stage_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !in_acc && !cfg_acc) |=> !s1_valid_q)
    else $error("work stage kept a retired item");

endmodule

`default_nettype wire
